// ===== rtl/rrp_pkg.sv =====
// Package for the per-CPU round-robin picker: widths, codes, shared types and helpers.
package rrp_pkg;

    localparam int SLOT_W   = 7;   // signed slot number, -1 means none
    localparam int CUR_W    = 6;   // cursor / slot index
    localparam int MASK_W   = 64;
    localparam int LANE_W   = 16;  // mask bits handled by one lane
    localparam int CFG_W    = 7;
    localparam int CFG_IX_W = 3;
    localparam int CPUS_W   = 3;
    localparam int CPU_ID_W = 2;
    localparam int OC_W     = 2;
    localparam int IDLE_N   = 4;

    localparam logic signed [SLOT_W-1:0] SLOT_NONE = -7'sd1;

    // outcome codes
    localparam logic [OC_W-1:0] OC_SWITCH = 2'd0;
    localparam logic [OC_W-1:0] OC_KEEP   = 2'd1;
    localparam logic [OC_W-1:0] OC_IDLE   = 2'd2;
    localparam logic [OC_W-1:0] OC_REJECT = 2'd3;

    // register indices
    localparam logic [CFG_IX_W-1:0] REG_SLOT_COUNT = 3'd0;
    localparam logic [CFG_IX_W-1:0] REG_CPU_COUNT  = 3'd1;
    localparam logic [CFG_IX_W-1:0] REG_IDLE_CPU0  = 3'd2;
    localparam logic [CFG_IX_W-1:0] REG_IDLE_CPU1  = 3'd3;
    localparam logic [CFG_IX_W-1:0] REG_IDLE_CPU2  = 3'd4;
    localparam logic [CFG_IX_W-1:0] REG_IDLE_CPU3  = 3'd5;

    // what one lane found
    typedef struct packed {
        logic             hi_found;   // runnable slot at or past the cursor
        logic [CUR_W-1:0] hi_idx;
        logic             any_found;  // any runnable slot (wrap case)
        logic [CUR_W-1:0] any_idx;
    } t_lane_hit;

    // per-item control held in the scan stage
    typedef struct packed {
        logic                     reject;
        logic                     keep;
        logic signed [SLOT_W-1:0] idle_slot;
        logic [SLOT_W-1:0]        slots;
    } t_pick_ctl;

    typedef struct packed {
        logic                     upd;
        logic [CUR_W-1:0]         next_cursor;
        logic signed [SLOT_W-1:0] picked;
        logic [OC_W-1:0]          outcome;
    } t_pick_res;

    // cursor modulo slot count, restoring, one quotient bit per step
    function automatic logic [CUR_W-1:0] mod_slots(input logic [CUR_W-1:0] c,
                                                   input logic [SLOT_W-1:0] s);
        logic [12:0] rem;
        logic [12:0] d;
        rem = 13'(c);
        d   = '0;
        for (int k = CUR_W - 1; k >= 0; k--) begin
            d = 13'(s) << k;
            if (rem >= d) begin
                rem = rem - d;
            end
        end
        return rem[CUR_W-1:0];
    endfunction

endpackage

// ===== rtl/per_cpu_round_robin_picker.sv =====
// Top level of the per-CPU round-robin slot picker.
//
// Use: present cpu id, current slot and runnable mask with start high while
// busy is low; that edge takes the word. The block answers with exactly one
// result word: o_done is high for one cycle with o_picked_slot and o_outcome
// (switch, keep current, idle slot, rejected). The receiver cannot stall, so
// the result must be captured in that cycle.
// A taken word is registered into the scan stage; the result and o_done are
// then registered in the result register. No new word is taken while busy is
// high. On capture the CPU's cursor is reduced modulo the slot count (six
// compare-subtract steps) and the request is masked; the scan stage runs the
// lane scan and merge, then registers the result and the new cursor. Busy is
// high for the scan cycle only, so the next word reads the updated cursor.
// Configuration: a write with i_cfg_we at index 0..5 (slot count, CPU count,
// idle slots of CPU 0..3) lands at that edge; write only while idle.
// Reset (synchronous, active low): cursors clear, slot count 64, CPU count 1,
// idle slots -1, no result pending.
module per_cpu_round_robin_picker #(
    parameter int MAX_SLOTS = 64,
    parameter int MAX_CPUS  = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request
    input  logic                                start,
    output logic                                busy,
    input  logic [rrp_pkg::CPU_ID_W-1:0]        i_cpu_id,
    input  logic signed [rrp_pkg::SLOT_W-1:0]   i_current_slot,
    input  logic [rrp_pkg::MASK_W-1:0]          i_runnable_mask,
    // result
    output logic                                o_done,
    output logic signed [rrp_pkg::SLOT_W-1:0]   o_picked_slot,
    output logic [rrp_pkg::OC_W-1:0]            o_outcome,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [rrp_pkg::CFG_IX_W-1:0]        i_cfg_idx,
    input  logic [rrp_pkg::CFG_W-1:0]           i_cfg_wdata
);

    localparam int LANES = (MAX_SLOTS + rrp_pkg::LANE_W - 1) / rrp_pkg::LANE_W;
    localparam int TOTAL = LANES * rrp_pkg::LANE_W;

    // configuration registers
    logic [rrp_pkg::SLOT_W-1:0]        r_slot_count;
    logic [rrp_pkg::CPUS_W-1:0]        r_cpu_count;
    logic signed [rrp_pkg::SLOT_W-1:0] r_idle [rrp_pkg::IDLE_N];

    // per-CPU cursors
    logic [rrp_pkg::CUR_W-1:0] r_cursor [MAX_CPUS];

    // scan stage
    logic                      r_busy;
    logic [rrp_pkg::CPU_ID_W-1:0] r_cpu;
    logic [TOTAL-1:0]          r_emask;
    logic [rrp_pkg::CUR_W-1:0] r_start;
    rrp_pkg::t_pick_ctl        r_ctl;

    // result register
    logic                              r_done;
    logic signed [rrp_pkg::SLOT_W-1:0] r_picked;
    logic [rrp_pkg::OC_W-1:0]          r_outcome;

    logic                      accept;
    logic [rrp_pkg::SLOT_W-1:0] slots;
    logic [rrp_pkg::CUR_W-1:0] cur_sel;
    logic [TOTAL-1:0]          n_emask;
    rrp_pkg::t_pick_ctl        n_ctl;
    rrp_pkg::t_lane_hit        w_hits [LANES];
    rrp_pkg::t_pick_res        w_res;

    assign accept = start && !busy;
    assign busy   = r_busy;

    // slot count: zero acts as one, large values saturate
    always_comb begin
        if (r_slot_count == '0) begin
            slots = rrp_pkg::SLOT_W'(1);
        end else if (r_slot_count > rrp_pkg::SLOT_W'(MAX_SLOTS)) begin
            slots = rrp_pkg::SLOT_W'(MAX_SLOTS);
        end else begin
            slots = r_slot_count;
        end
    end

    // cursor of the requesting CPU
    always_comb begin
        cur_sel = '0;
        for (int j = 0; j < MAX_CPUS; j++) begin
            if (i_cpu_id == rrp_pkg::CPU_ID_W'(j)) begin
                cur_sel = r_cursor[j];
            end
        end
    end

    // runnable slots in range, current slot removed
    always_comb begin
        for (int i = 0; i < TOTAL; i++) begin
            n_emask[i] = i_runnable_mask[i]
                         && (rrp_pkg::SLOT_W'(i) < slots)
                         && !(!i_current_slot[rrp_pkg::SLOT_W-1]
                              && i_current_slot[rrp_pkg::CUR_W-1:0]
                                 == rrp_pkg::CUR_W'(i));
        end
    end

    always_comb begin
        n_ctl.reject    = (rrp_pkg::CPUS_W'(i_cpu_id) >= r_cpu_count)
                          || (int'(i_cpu_id) >= MAX_CPUS);
        n_ctl.keep      = !i_current_slot[rrp_pkg::SLOT_W-1]
                          && i_runnable_mask[i_current_slot[rrp_pkg::CUR_W-1:0]];
        n_ctl.idle_slot = r_idle[i_cpu_id];
        n_ctl.slots     = slots;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= rrp_pkg::SLOT_W'(64);
            r_cpu_count  <= rrp_pkg::CPUS_W'(1);
            for (int k = 0; k < rrp_pkg::IDLE_N; k++) begin
                r_idle[k] <= rrp_pkg::SLOT_NONE;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rrp_pkg::REG_SLOT_COUNT: r_slot_count <= i_cfg_wdata;
                rrp_pkg::REG_CPU_COUNT:  r_cpu_count  <= i_cfg_wdata[rrp_pkg::CPUS_W-1:0];
                rrp_pkg::REG_IDLE_CPU0:  r_idle[0]    <= $signed(i_cfg_wdata);
                rrp_pkg::REG_IDLE_CPU1:  r_idle[1]    <= $signed(i_cfg_wdata);
                rrp_pkg::REG_IDLE_CPU2:  r_idle[2]    <= $signed(i_cfg_wdata);
                rrp_pkg::REG_IDLE_CPU3:  r_idle[3]    <= $signed(i_cfg_wdata);
                default: ;
            endcase
        end
    end

    // stage 1: capture request, start point reduced modulo slot count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cpu   <= i_cpu_id;
            r_emask <= n_emask;
            r_start <= rrp_pkg::mod_slots(cur_sel, slots);
            r_ctl   <= n_ctl;
        end
    end

    // scan lanes
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        rrp_lane #(
            .LANE_BASE(g * rrp_pkg::LANE_W)
        ) u_lane (
            .i_bits (r_emask[g*rrp_pkg::LANE_W +: rrp_pkg::LANE_W]),
            .i_start(r_start),
            .o_hit  (w_hits[g])
        );
    end

    rrp_merge #(
        .LANES(LANES)
    ) u_merge (
        .i_hits(w_hits),
        .i_ctl (r_ctl),
        .o_res (w_res)
    );

    // stage 2: result word and cursor update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
            for (int j = 0; j < MAX_CPUS; j++) begin
                r_cursor[j] <= '0;
            end
        end else begin
            r_done <= r_busy;
            for (int j = 0; j < MAX_CPUS; j++) begin
                if (r_busy && w_res.upd && r_cpu == rrp_pkg::CPU_ID_W'(j)) begin
                    r_cursor[j] <= w_res.next_cursor;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_picked  <= w_res.picked;
            r_outcome <= w_res.outcome;
        end
    end

    assign o_done        = r_done;
    assign o_picked_slot = r_picked;
    assign o_outcome     = r_outcome;

    // checks
    a_done_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result word without a scan cycle");

    a_accept_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy ##1 (o_done && !busy)))
        else $error("accepted word did not complete in two cycles");

    a_reject_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_outcome == rrp_pkg::OC_REJECT) |-> o_picked_slot == rrp_pkg::SLOT_NONE)
        else $error("rejected word carries a slot");

    a_switch_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_outcome == rrp_pkg::OC_SWITCH)
            |-> (!o_picked_slot[rrp_pkg::SLOT_W-1]
                 && $unsigned(o_picked_slot) < slots))
        else $error("switch to a slot outside the slot count");

endmodule

// ===== rtl/rrp_lane.sv =====
// One scan lane: first runnable slot in its slice, at/after the cursor and overall.
module rrp_lane #(
    parameter int LANE_BASE = 0
) (
    input  logic [rrp_pkg::LANE_W-1:0] i_bits,
    input  logic [rrp_pkg::CUR_W-1:0]  i_start,
    output rrp_pkg::t_lane_hit         o_hit
);

    always_comb begin
        o_hit = '0;
        // walk downwards so the lowest index wins
        for (int j = rrp_pkg::LANE_W - 1; j >= 0; j--) begin
            if (i_bits[j]) begin
                o_hit.any_found = 1'b1;
                o_hit.any_idx   = rrp_pkg::CUR_W'(LANE_BASE + j);
                if (rrp_pkg::CUR_W'(LANE_BASE + j) >= i_start) begin
                    o_hit.hi_found = 1'b1;
                    o_hit.hi_idx   = rrp_pkg::CUR_W'(LANE_BASE + j);
                end
            end
        end
    end

endmodule

// ===== rtl/rrp_merge.sv =====
// Merge of lane results into the pick, outcome and next cursor.
module rrp_merge #(
    parameter int LANES = 4
) (
    input  rrp_pkg::t_lane_hit i_hits [LANES],
    input  rrp_pkg::t_pick_ctl i_ctl,
    output rrp_pkg::t_pick_res o_res
);

    logic                      hi_found;
    logic [rrp_pkg::CUR_W-1:0] hi_idx;
    logic                      any_found;
    logic [rrp_pkg::CUR_W-1:0] any_idx;
    logic [rrp_pkg::CUR_W-1:0] sel;
    logic [rrp_pkg::SLOT_W-1:0] nxt;

    always_comb begin
        hi_found  = 1'b0;
        hi_idx    = '0;
        any_found = 1'b0;
        any_idx   = '0;
        for (int l = LANES - 1; l >= 0; l--) begin
            if (i_hits[l].hi_found) begin
                hi_found = 1'b1;
                hi_idx   = i_hits[l].hi_idx;
            end
            if (i_hits[l].any_found) begin
                any_found = 1'b1;
                any_idx   = i_hits[l].any_idx;
            end
        end
    end

    assign sel = hi_found ? hi_idx : any_idx;
    assign nxt = rrp_pkg::SLOT_W'(sel) + 7'd1;

    always_comb begin
        o_res             = '0;
        o_res.next_cursor = (nxt >= i_ctl.slots) ? '0 : nxt[rrp_pkg::CUR_W-1:0];
        if (i_ctl.reject) begin
            o_res.picked  = rrp_pkg::SLOT_NONE;
            o_res.outcome = rrp_pkg::OC_REJECT;
        end else if (hi_found || any_found) begin
            o_res.upd     = 1'b1;
            o_res.picked  = $signed({1'b0, sel});
            o_res.outcome = rrp_pkg::OC_SWITCH;
        end else if (i_ctl.keep) begin
            o_res.picked  = rrp_pkg::SLOT_NONE;
            o_res.outcome = rrp_pkg::OC_KEEP;
        end else begin
            o_res.picked  = i_ctl.idle_slot;
            o_res.outcome = rrp_pkg::OC_IDLE;
        end
    end

endmodule

// ===== verif/per_cpu_round_robin_picker_test.sv =====
// Self-checking testbench for the per-CPU round-robin slot picker.
`timescale 1ns / 100ps

module per_cpu_round_robin_picker_test;
    import rrp_pkg::*;

    localparam int N_SLOTS = 64;
    localparam int N_CPUS  = 4;

    // One expected answer: the slot and how it was arrived at.
    typedef struct packed {
        logic signed [SLOT_W-1:0] slot;
        logic [OC_W-1:0]          outcome;
    } pick_t;

    // Scoreboard: mirrors the picker's registers and cursors, predicts
    // the answer to every accepted request word and checks results in order.
    class pick_scoreboard;
        logic [CFG_W-1:0]         slot_count;
        logic [CPUS_W-1:0]        cpu_count;
        logic signed [SLOT_W-1:0] idle_slot [IDLE_N];
        logic [CUR_W-1:0]         cursor [N_CPUS];
        pick_t                    expected_picks [$];
        int                       failures;

        function new();
            slot_count = 7'd64;
            cpu_count  = 3'd1;
            failures   = 0;
            for (int k = 0; k < IDLE_N; k++) begin
                idle_slot[k] = SLOT_NONE;
            end
            for (int k = 0; k < N_CPUS; k++) begin
                cursor[k] = '0;
            end
        endfunction

        function void write_reg(input logic [CFG_IX_W-1:0] idx, input logic [CFG_W-1:0] data);
            case (idx)
                REG_SLOT_COUNT: slot_count = data;
                REG_CPU_COUNT:  cpu_count = data[CPUS_W-1:0];
                REG_IDLE_CPU0:  idle_slot[0] = data;
                REG_IDLE_CPU1:  idle_slot[1] = data;
                REG_IDLE_CPU2:  idle_slot[2] = data;
                REG_IDLE_CPU3:  idle_slot[3] = data;
                default: ;
            endcase
        endfunction

        function void note_request(input logic [CPU_ID_W-1:0] cpu,
                                   input logic signed [SLOT_W-1:0] cur,
                                   input logic [MASK_W-1:0] mask);
            pick_t e;
            int    slots;
            int    first;
            int    s;
            int    nxt;
            int    cur_i;
            bit    hit;
            cur_i     = cur;
            hit       = 1'b0;
            e.slot    = SLOT_NONE;
            e.outcome = OC_REJECT;
            if (int'(cpu) < int'(cpu_count) && int'(cpu) < N_CPUS) begin
                slots = slot_count;
                if (slots == 0) slots = 1;
                if (slots > N_SLOTS) slots = N_SLOTS;
                first = int'(cursor[cpu]) % slots;
                for (int n = 0; n < slots && !hit; n++) begin
                    s = first + n;
                    if (s >= slots) s -= slots;
                    if (s != cur_i && mask[s]) begin
                        hit = 1'b1;
                        nxt = s + 1;
                        if (nxt >= slots) nxt = 0;
                        cursor[cpu] = nxt[CUR_W-1:0];
                        e.slot      = s[SLOT_W-1:0];
                        e.outcome   = OC_SWITCH;
                    end
                end
                if (!hit) begin
                    if (cur_i >= 0 && mask[cur_i]) begin
                        e.outcome = OC_KEEP;
                    end else begin
                        e.slot    = idle_slot[cpu];
                        e.outcome = OC_IDLE;
                    end
                end
            end
            expected_picks.push_back(e);
        endfunction

        function void check_result(input logic signed [SLOT_W-1:0] slot,
                                   input logic [OC_W-1:0] outcome);
            pick_t e;
            if (expected_picks.size() == 0) begin
                failures++;
                if (failures <= 10) begin
                    $display("unexpected result: slot %0d outcome %0d", slot, outcome);
                end
            end else begin
                e = expected_picks.pop_front();
                if (slot !== e.slot || outcome !== e.outcome) begin
                    failures++;
                    if (failures <= 10) begin
                        $display("mismatch: expected slot %0d outcome %0d, got slot %0d outcome %0d",
                                 e.slot, e.outcome, slot, outcome);
                    end
                end
            end
        endfunction

        function int pending();
            return expected_picks.size();
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic [CPU_ID_W-1:0]      i_cpu_id;
    logic signed [SLOT_W-1:0] i_current_slot;
    logic [MASK_W-1:0]        i_runnable_mask;
    logic                     o_done;
    logic signed [SLOT_W-1:0] o_picked_slot;
    logic [OC_W-1:0]          o_outcome;
    logic                     i_cfg_we;
    logic [CFG_IX_W-1:0]      i_cfg_idx;
    logic [CFG_W-1:0]         i_cfg_wdata;

    pick_scoreboard           sb;
    int                       eff_slots;   // slot count as the scan sees it
    int                       cfg_cpus;
    logic signed [SLOT_W-1:0] idle_vals [IDLE_N];

    per_cpu_round_robin_picker #(
        .MAX_SLOTS(N_SLOTS),
        .MAX_CPUS(N_CPUS)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_cpu_id(i_cpu_id),
        .i_current_slot(i_current_slot),
        .i_runnable_mask(i_runnable_mask),
        .o_done(o_done),
        .o_picked_slot(o_picked_slot),
        .o_outcome(o_outcome),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Result side: the receiver never stalls, every strobe is one word.
    // Values are read at the edge, before the block's own updates land.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            sb.check_result(o_picked_slot, o_outcome);
        end
    end

    // One request word. An optional gap with start low comes first; the
    // word counts as taken at the first edge where busy is seen low. The
    // task returns in that edge's time step, so a following word with no
    // gap keeps start high without a second assignment in this step.
    task automatic send_pick(input logic [CPU_ID_W-1:0] cpu,
                             input logic signed [SLOT_W-1:0] cur,
                             input logic [MASK_W-1:0] mask,
                             input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_cpu_id        <= cpu;
        i_current_slot  <= cur;
        i_runnable_mask <= mask;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_request(cpu, cur, mask);
    endtask

    // Sender stands still until every outstanding word has been answered.
    // Always moves on by at least one edge, so start is never lowered and
    // raised within one time step.
    task automatic hold_until_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic cfg_write(input logic [CFG_IX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        sb.write_reg(idx, data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Full register set; idle slots come from idle_vals. Only called idle.
    task automatic apply_setting(input logic [CFG_W-1:0] slots, input logic [CPUS_W-1:0] cpus);
        cfg_write(REG_SLOT_COUNT, slots);
        cfg_write(REG_CPU_COUNT, CFG_W'(cpus));
        for (int k = 0; k < IDLE_N; k++) begin
            cfg_write(REG_IDLE_CPU0 + CFG_IX_W'(k), idle_vals[k]);
        end
        eff_slots = (slots == 0) ? 1 : ((slots > N_SLOTS) ? N_SLOTS : int'(slots));
        cfg_cpus  = cpus;
    endtask

    function automatic logic signed [SLOT_W-1:0] rand_idle();
        case ($urandom_range(0, 4))
            0:       rand_idle = SLOT_NONE;
            1:       rand_idle = 7'sd63;
            2:       rand_idle = 7'sd0;
            3:       rand_idle = SLOT_W'($urandom_range(0, 63));
            default: rand_idle = SLOT_W'($urandom);
        endcase
    endfunction

    initial begin
        int                       gap;
        int                       burst_left;
        int                       kind;
        int                       cpu_lim;
        bit                       quiet;
        logic [CFG_W-1:0]         r_slots;
        logic [CPU_ID_W-1:0]      r_cpu;
        logic signed [SLOT_W-1:0] r_cur;
        logic [MASK_W-1:0]        r_mask;

        sb              = new();
        eff_slots       = N_SLOTS;
        cfg_cpus        = 1;
        burst_left      = 0;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_cpu_id        = '0;
        i_current_slot  = '0;
        i_runnable_mask = '0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_wdata     = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed, reset settings: 64 slots, one CPU, no idle slot ---
        send_pick(2'd0, SLOT_NONE, 64'h0, 0);                    // nothing runnable, idle -1
        send_pick(2'd0, SLOT_NONE, '1, 0);                       // first pick from cursor 0
        send_pick(2'd0, 7'sd1, '1, 1);                           // current slot skipped
        send_pick(2'd0, 7'sd63, 64'h8000_0000_0000_0000, 0);     // only current runnable: keep
        send_pick(2'd1, 7'sd0, '1, 0);                           // CPU beyond count
        send_pick(2'd3, 7'sd63, '1, 2);                          // top CPU rejected too
        send_pick(2'd0, 7'sd5, 64'h0, 0);
        send_pick(2'd0, SLOT_NONE, 64'h8000_0000_0000_0000, 0);  // top slot, cursor wraps
        hold_until_drained();

        // --- small slot count, all CPUs, mixed idle slots ---
        idle_vals[0] = 7'sd0;
        idle_vals[1] = 7'sd63;
        idle_vals[2] = SLOT_NONE;
        idle_vals[3] = 7'sd17;
        apply_setting(7'd4, 3'd4);
        send_pick(2'd2, -7'sd64, 64'hFFFF_FFFF_FFFF_FFF0, 0);    // mask only past slot count
        send_pick(2'd1, 7'sd10, 64'h0000_0000_0000_0400, 0);     // current beyond count, kept
        send_pick(2'd1, 7'sd10, 64'h5, 1);
        send_pick(2'd3, SLOT_NONE, 64'h0, 0);
        send_pick(2'd0, 7'sd0, 64'h1, 0);                        // keep current
        send_pick(2'd0, 7'sd0, 64'h0, 0);                        // idle slot 0
        hold_until_drained();

        // zero slots counts as one; zero CPUs rejects everything
        apply_setting(7'd0, 3'd0);
        send_pick(2'd0, SLOT_NONE, '1, 0);
        hold_until_drained();
        apply_setting(7'd0, 3'd7);
        send_pick(2'd3, SLOT_NONE, 64'h1, 0);
        send_pick(2'd3, 7'sd0, 64'h1, 0);
        hold_until_drained();

        // oversized slot count saturates; then a short count leaves stale cursors
        apply_setting(7'd127, 3'd4);
        send_pick(2'd2, SLOT_NONE, 64'h8000_0000_0000_0000, 0);
        send_pick(2'd1, SLOT_NONE, 64'h4000_0000_0000_0000, 0);
        hold_until_drained();
        apply_setting(7'd3, 3'd4);
        send_pick(2'd1, SLOT_NONE, 64'h7, 0);
        send_pick(2'd1, 7'sd2, 64'h6, 0);
        hold_until_drained();

        // --- random phases, one register setting each ---
        for (int ph = 0; ph < 8; ph++) begin
            for (int k = 0; k < IDLE_N; k++) begin
                idle_vals[k] = rand_idle();
            end
            case (ph)
                0: begin
                    idle_vals[0] = 7'sd63;
                    idle_vals[1] = 7'sd0;
                    idle_vals[2] = SLOT_NONE;
                    apply_setting(7'd64, 3'd4);
                end
                1: apply_setting(7'd1, 3'd2);
                2: apply_setting(7'd2, 3'd4);
                3: apply_setting(CFG_W'($urandom_range(3, 63)), 3'd4);
                4: apply_setting(7'd64, 3'd3);
                5: begin
                    r_slots = $urandom_range(0, 1) ? 7'd0 : CFG_W'($urandom_range(65, 127));
                    apply_setting(r_slots, 3'd4);
                end
                6: apply_setting(CFG_W'($urandom_range(1, 64)), CPUS_W'($urandom_range(0, 7)));
                default: apply_setting(7'd33, 3'd1);
            endcase
            cpu_lim = (cfg_cpus == 0) ? 1 : ((cfg_cpus > N_CPUS) ? N_CPUS : cfg_cpus);
            quiet   = (ph == 3 || ph == 7);   // back-to-back words, no gaps

            for (int n = 0; n < 150; n++) begin
                if ($urandom_range(0, 6) == 0) r_cpu = CPU_ID_W'($urandom_range(0, 3));
                else r_cpu = CPU_ID_W'($urandom_range(0, cpu_lim - 1));

                kind = $urandom_range(0, 9);
                if (kind < 7) r_cur = SLOT_W'($urandom_range(0, eff_slots - 1));
                else if (kind == 7) r_cur = SLOT_NONE;
                else r_cur = SLOT_W'($urandom);

                // sparse in-range masks make the cursor walk; dense ones
                // and odd shapes cover the rest
                case ($urandom_range(0, 9))
                    0: r_mask = '0;
                    1: r_mask = '1;
                    2: r_mask = 64'd1 << $urandom_range(0, 63);
                    3: r_mask = 64'd1 << $urandom_range(0, eff_slots - 1);
                    4, 5, 6: r_mask = (64'd1 << $urandom_range(0, eff_slots - 1))
                                    | (64'd1 << $urandom_range(0, eff_slots - 1))
                                    | (64'd1 << $urandom_range(0, eff_slots - 1));
                    7, 8: r_mask = {$urandom, $urandom};
                    default: r_mask = (r_cur >= 0) ? (64'd1 << r_cur) : {$urandom, $urandom};
                endcase

                // bursts of random length, random gaps between them outside the quiet phases
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap = quiet ? 0 : $urandom_range(1, 6);
                end else begin
                    gap = 0;
                end
                burst_left--;

                if (ph == 2 && n == 75) hold_until_drained();
                send_pick(r_cpu, r_cur, r_mask, gap);
            end
            hold_until_drained();
        end

        // wind down: wait for the last answers, then wait out any stray results
        start <= 1'b0;
        for (int k = 0; k < 1000 && sb.pending() != 0; k++) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
